// ----- rtl/bucketed_hash_set_defines.svh -----
// bucketed_hash_set_defines.svh: assertion macros for the bucketed hash set
// used by the top level; no other dependencies
`ifndef BUCKETED_HASH_SET_DEFINES_SVH
`define BUCKETED_HASH_SET_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BHS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bhs_pkg.sv -----
// bhs_pkg: payload types, request codes and controller/datapath handshake
// structs shared by the bucketed hash set modules; no dependencies
`timescale 1ns / 1ps

package bhs_pkg;

  localparam int KEY_W = 20;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic was_present;
    logic overflow;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic mod_step;
    logic rd_en;
    logic upd_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
  } status_t;

endpackage

// ----- rtl/bucketed_hash_set.sv -----
// bucketed_hash_set: a request runs the two-step reciprocal bucket
// remainder and the read-then-write of one bucket row, whose write waits
// for a free output slot; no new request is taken until then. after
// reset the valid bits of all NUM_BUCKETS rows are cleared, one row a
// cycle, with in_ready_o held low.
`timescale 1ns / 1ps

module bucketed_hash_set #(
  parameter int NUM_BUCKETS = 128,
  parameter int WAYS        = 8,
  parameter int KEY_BITS    = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bhs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bhs_pkg::out_t out_data_o
);
  import bhs_pkg::*;

`include "bucketed_hash_set_defines.svh"

  cmd_t    cmd;
  status_t status;
  out_t    result;
  out_t    out_q;
  logic    out_valid_q;
  logic    out_free;

  assign out_free = !out_valid_q || out_ready_i;

  bhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  bhs_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .status_o  (status),
    .result_o  (result)
  );

  // output register, holds a beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.upd_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.upd_en) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BHS_ASSERT_SAME(a_no_accept_in_update, clk_i, rst_ni, cmd.upd_en, !in_ready_o, "accept during update")
  `BHS_ASSERT_NEXT(a_update_gives_beat, clk_i, rst_ni, cmd.upd_en, out_valid_o, "update without output beat")
  `BHS_ASSERT_SAME(a_beat_from_update, clk_i, rst_ni, $rose(out_valid_q), $past(cmd.upd_en), "output beat without update")
  `BHS_ASSERT_SAME(a_ovf_not_present, clk_i, rst_ni, out_valid_o, !(out_data_o.overflow && out_data_o.was_present), "overflow on present key")

endmodule

// ----- rtl/bhs_ctrl.sv -----
// bhs_ctrl: sequencing state machine for the bucketed hash set
// depends on bhs_pkg for the command and status structs
`timescale 1ns / 1ps

module bhs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_free_i,
  input  bhs_pkg::status_t status_i,
  output logic             in_ready_o,
  output bhs_pkg::cmd_t    cmd_o
);
  import bhs_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_MOD    = 5'b00100,
    S_READ   = 5'b01000,
    S_UPDATE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        // write back and push the result together, once the output slot is free
        if (out_free_i) begin
          cmd_o.upd_en = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/bhs_datapath.sv -----
// bhs_datapath: bucket remainder unit, bucket row memories and way compare
// depends on bhs_pkg for payload, command and status types
`timescale 1ns / 1ps

module bhs_datapath #(
  parameter int NUM_BUCKETS = 128,
  parameter int WAYS        = 8,
  parameter int KEY_BITS    = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bhs_pkg::cmd_t    cmd_i,
  input  bhs_pkg::in_t     in_data_i,
  output bhs_pkg::status_t status_o,
  output bhs_pkg::out_t    result_o
);
  import bhs_pkg::*;

  localparam int RW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [RW:0]    NB_W     = (RW + 1)'(NUM_BUCKETS);
  localparam logic [RW-1:0]  CLR_LAST = RW'(NUM_BUCKETS - 1);
  // floor(2^KEY_BITS / NUM_BUCKETS), so the quotient estimate is exact or one short
  localparam logic [KEY_BITS:0] RECIP =
    (KEY_BITS + 1)'((64'd1 << KEY_BITS) / 64'(NUM_BUCKETS));

  logic [1:0]          req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] quo_q;
  logic [RW-1:0]       rem_q;
  logic                mod_ph_q;
  logic [RW-1:0]       clr_q;

  logic [2*KEY_BITS:0] quo_prod;
  logic [RW:0]         key_lo, quo_lo, rem_try;
  logic [RW-1:0]       rem_d;

  logic [WAYS*KEY_BITS-1:0] key_mem [NUM_BUCKETS];
  logic [WAYS-1:0]          val_mem [NUM_BUCKETS];
  logic [WAYS*KEY_BITS-1:0] key_rd_q;
  logic [WAYS-1:0]          val_rd_q;

  logic [WAYS-1:0]          hit_vec, free_vec, first_free, val_new;
  logic [WAYS*KEY_BITS-1:0] key_row_new;
  logic                     present, full, is_add, is_rem, do_insert;

  assign status_o.clr_last = (clr_q == CLR_LAST);
  assign status_o.mod_last = mod_ph_q;

  // request capture and two-step bucket remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      mod_ph_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) mod_ph_q <= 1'b0;
      else if (cmd_i.mod_step) mod_ph_q <= ~mod_ph_q;
    end
  end

  // quotient estimate, then remainder with one correcting subtract
  always_comb begin
    quo_prod = (2*KEY_BITS+1)'(key_q) * (2*KEY_BITS+1)'(RECIP);
    key_lo   = (RW+1)'(key_q);
    quo_lo   = (RW+1)'(quo_q) * NB_W;
    rem_try  = key_lo - quo_lo;
    rem_d    = (rem_try >= NB_W) ? RW'(rem_try - NB_W) : RW'(rem_try);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i.req_type;
      key_q <= KEY_BITS'(in_data_i.key);
    end else if (cmd_i.mod_step) begin
      if (!mod_ph_q) quo_q <= quo_prod[2*KEY_BITS-1:KEY_BITS];
      else rem_q <= rem_d;
    end
  end

  // bucket row memories, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      key_rd_q <= key_mem[rem_q];
      val_rd_q <= val_mem[rem_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) val_mem[clr_q] <= '0;
    else if (cmd_i.upd_en) val_mem[rem_q] <= val_new;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en && do_insert) key_mem[rem_q] <= key_row_new;
  end

  // compare all ways of the row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = val_rd_q[w] && (key_rd_q[w*KEY_BITS +: KEY_BITS] == key_q);
    end
    free_vec   = ~val_rd_q;
    first_free = free_vec & (~free_vec + 1'b1);
    present    = |hit_vec;
    full       = ~|free_vec;
    is_add     = (req_q == OP_ADD);
    is_rem     = (req_q == OP_REMOVE);
    do_insert  = is_add && !present && !full;

    val_new = val_rd_q;
    if (do_insert) val_new = val_rd_q | first_free;
    else if (is_rem && present) val_new = val_rd_q & ~hit_vec;

    for (int w = 0; w < WAYS; w++) begin
      key_row_new[w*KEY_BITS +: KEY_BITS] =
        first_free[w] ? key_q : key_rd_q[w*KEY_BITS +: KEY_BITS];
    end

    result_o.was_present = present;
    result_o.overflow    = is_add && !present && full;
  end

endmodule
